>>> hw/rtl/multi_timer_deadline_scheduler_assert.svh
// Assertion macros used by the timer scheduler top level
`ifndef MULTI_TIMER_DEADLINE_SCHEDULER_ASSERT_SVH
`define MULTI_TIMER_DEADLINE_SCHEDULER_ASSERT_SVH
// Implication checked every clock outside reset
`define MTDS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define MTDS_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

>>> hw/rtl/mtds_pkg.sv
// Package: types, codes and constants of the timer scheduler
package mtds_pkg;
    localparam int TIMER_SLOTS_DEF = 16;
    localparam int MAX_FIRES_DEF   = 63;
    localparam logic [47:0] MAX48  = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0, OP_START_AT = 2'd1, OP_START_AFTER = 2'd2, OP_STOP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_START = 2'd0, KIND_STOP = 2'd1, KIND_FIRED = 2'd2, KIND_TICK_DONE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_FULL = 2'd2, ST_RSVD = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DIV, S_MUL, S_ADD, S_WRITE, S_FIRE_RD, S_FIRE_WR,
        S_EMIT, S_WAIT
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [47:0] now_ms;
        logic [47:0] start_ms;
        logic [31:0] period_ms;
        logic [3:0]  slot_id;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  timer_slot;
        logic [1:0]  status;
        logic [47:0] next_deadline_ms;
        logic        armed;
        logic        last;
    } t_rsp;

    // Control from the sequencer to the divider
    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [31:0] divisor;
    } t_div_ctl;

    // Status from the divider back to the sequencer
    typedef struct packed {
        logic        done;
        logic [47:0] quotient;
    } t_div_sts;
endpackage

>>> hw/rtl/multi_timer_deadline_scheduler.sv
// Top level of the timer scheduler: sequencer, slot table and divider
// Usage:
//   Input channel i_req_valid / o_req_stall carries one request (tick, start at,
//   start after, stop). Output channel o_rsp_valid / i_rsp_stall carries results.
//   Start and stop give one result; a tick gives one fired result per expired
//   timer (earliest first, at most MAX_FIRES per tick) and then a tick-done.
//   Each result carries the earliest pending deadline and an armed flag.
// Sequence:
//   Every result but a tick-done that follows a fired result comes after a
//   scan of the slot table through a single compare unit reading the deadline
//   RAM one entry a cycle. A start at a past time first runs a serial 48-bit
//   divide, then two 25x32 partial products and the final add. A tick reads
//   the period of each fired slot, re-arms or frees that slot and rescans.
//   One request is worked on at a time; stall stays high until its last result
//   is taken.
// Reset:
//   Synchronous active-low reset clears all slot valid bits; no timer is armed.
//   A stalled result holds its value until taken.
module multi_timer_deadline_scheduler #(
    parameter int TIMER_SLOTS = mtds_pkg::TIMER_SLOTS_DEF,
    parameter int MAX_FIRES   = mtds_pkg::MAX_FIRES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  mtds_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    output mtds_pkg::t_rsp  o_rsp
);
    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1) + 1;

    mtds_pkg::t_state r_state, n_state;
    mtds_pkg::t_req   r_req, n_req;
    logic [TIMER_SLOTS-1:0] r_valid, n_valid;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [AW-1:0]    r_best, n_best;
    logic [47:0]      r_best_dl, n_best_dl;
    logic             r_found, n_found;
    logic [5:0]       r_fires, n_fires;
    logic [64:0]      r_acc, n_acc;
    logic             r_mhalf, n_mhalf;
    mtds_pkg::t_rsp   r_rsp, n_rsp;
    logic             r_rsp_valid, n_rsp_valid;
    logic             r_free_ok, n_free_ok;
    logic [AW-1:0]    r_free, n_free;
    logic             r_post, n_post;

    // table memories
    logic             w_we;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [47:0]      w_dl_wdata, w_dl_rdata;
    logic [31:0]      w_pr_wdata, w_pr_rdata;
    logic             w_pr_we;

    mtds_pkg::t_div_ctl w_div_ctl;
    mtds_pkg::t_div_sts w_div_sts;

    mtds_ram #(.WIDTH(48), .DEPTH(TIMER_SLOTS)) u_dl_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_dl_wdata),
        .i_raddr(w_raddr), .o_rdata(w_dl_rdata));
    mtds_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_pr_ram (
        .i_clk(i_clk), .i_we(w_pr_we), .i_waddr(w_waddr), .i_wdata(w_pr_wdata),
        .i_raddr(w_raddr), .o_rdata(w_pr_rdata));
    mtds_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_div_ctl), .o_sts(w_div_sts));

    logic [AW-1:0] w_scan_idx;
    logic [48:0]   w_sum;
    logic [47:0]   w_delta;
    logic [24:0]   w_mul_a;
    logic [56:0]   w_mul;

    assign w_scan_idx = r_cnt[AW-1:0] - AW'(1);
    assign w_delta    = r_req.now_ms - r_req.start_ms;

    // shared multiplier: high multiplicand part first, then the low part
    assign w_mul_a = r_mhalf ? {1'b0, r_acc[23:0]} : r_acc[48:24];
    assign w_mul   = w_mul_a * r_req.period_ms;

    // sequencer
    always_comb begin
        n_state = r_state; n_req = r_req; n_valid = r_valid; n_cnt = r_cnt;
        n_best = r_best; n_best_dl = r_best_dl; n_found = r_found;
        n_fires = r_fires; n_acc = r_acc; n_mhalf = r_mhalf; n_rsp = r_rsp;
        n_rsp_valid = r_rsp_valid; n_free_ok = r_free_ok; n_free = r_free;
        n_post = r_post;
        w_we = 1'b0; w_pr_we = 1'b0; w_waddr = r_best; w_raddr = r_cnt[AW-1:0];
        w_dl_wdata = r_acc[47:0]; w_pr_wdata = r_req.period_ms;
        w_div_ctl.start = 1'b0; w_div_ctl.dividend = w_delta;
        w_div_ctl.divisor = r_req.period_ms;
        w_sum = '0;
        case (r_state)
            mtds_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_req = i_req;
                    n_fires = '0;
                    n_free_ok = 1'b0;
                    n_free = '0;
                    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
                        if (!r_valid[i]) begin
                            n_free_ok = 1'b1;
                            n_free = AW'(i);
                        end
                    end
                    n_post = 1'b0;
                    n_cnt = '0; n_found = 1'b0;
                    case (mtds_pkg::t_op'(i_req.operation))
                        mtds_pkg::OP_TICK: begin
                            n_state = mtds_pkg::S_SCAN;
                        end
                        mtds_pkg::OP_STOP: begin
                            n_post = 1'b1;
                            n_state = mtds_pkg::S_SCAN;
                            if (({28'd0, i_req.slot_id} < 32'(TIMER_SLOTS))
                                    && r_valid[AW'(i_req.slot_id)]) begin
                                n_valid[AW'(i_req.slot_id)] = 1'b0;
                                n_rsp.status = mtds_pkg::ST_OK;
                            end else begin
                                n_rsp.status = mtds_pkg::ST_NOT_FOUND;
                            end
                            n_rsp.kind = mtds_pkg::KIND_STOP;
                            n_rsp.timer_slot = i_req.slot_id;
                        end
                        default: begin
                            n_rsp.kind = mtds_pkg::KIND_START;
                            if (!n_free_ok) begin
                                n_post = 1'b1;
                                n_rsp.status = mtds_pkg::ST_FULL;
                                n_rsp.timer_slot = '0;
                                n_state = mtds_pkg::S_SCAN;
                            end else begin
                                n_rsp.status = mtds_pkg::ST_OK;
                                n_rsp.timer_slot = 4'(n_free);
                                if (i_req.operation == mtds_pkg::OP_START_AT
                                        && i_req.period_ms != '0
                                        && i_req.now_ms > i_req.start_ms) begin
                                    n_state = mtds_pkg::S_DIV;
                                    n_mhalf = 1'b0;
                                end else if (i_req.operation == mtds_pkg::OP_START_AT) begin
                                    n_acc = {17'd0, i_req.start_ms};
                                    n_state = mtds_pkg::S_WRITE;
                                end else begin
                                    n_acc = {16'd0, {1'b0, i_req.now_ms} + {1'b0, i_req.start_ms}};
                                    n_state = mtds_pkg::S_WRITE;
                                end
                            end
                        end
                    endcase
                    if (n_state == mtds_pkg::S_DIV) begin
                        // divider is started the next cycle from r_req
                        n_cnt = '0;
                    end
                end
            end
            mtds_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    w_div_ctl.start = 1'b1;
                    n_cnt = CW'(1);
                end else if (w_div_sts.done) begin
                    // quotient + 1, kept in the low 49 bits
                    n_acc = {16'd0, {1'b0, w_div_sts.quotient} + 49'd1};
                    n_mhalf = 1'b0;
                    n_state = mtds_pkg::S_MUL;
                end
            end
            mtds_pkg::S_MUL: begin
                // (q+1) * period in two 25x32 partial products
                if (!r_mhalf) begin
                    n_acc = {w_mul[40:0], r_acc[23:0]};
                    n_mhalf = 1'b1;
                end else begin
                    n_acc = {r_acc[64:24], 24'd0} + 65'(w_mul);
                    n_state = mtds_pkg::S_ADD;
                end
            end
            mtds_pkg::S_ADD: begin
                n_acc = r_acc + 65'(r_req.start_ms);
                n_state = mtds_pkg::S_WRITE;
            end
            mtds_pkg::S_WRITE: begin
                w_we = 1'b1; w_pr_we = 1'b1; w_waddr = r_free;
                w_dl_wdata = (r_acc > 65'(mtds_pkg::MAX48)) ? mtds_pkg::MAX48 : r_acc[47:0];
                n_valid[r_free] = 1'b1;
                n_post = 1'b1;
                n_cnt = '0; n_found = 1'b0;
                n_state = mtds_pkg::S_SCAN;
            end
            mtds_pkg::S_SCAN: begin
                // compare one registered RAM entry a cycle
                if (r_cnt != '0) begin
                    if (r_valid[w_scan_idx]
                            && (!r_found || w_dl_rdata < r_best_dl)) begin
                        n_found = 1'b1;
                        n_best = w_scan_idx;
                        n_best_dl = w_dl_rdata;
                    end
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(TIMER_SLOTS)) begin
                    if (r_post) begin
                        n_rsp.next_deadline_ms = n_found ? n_best_dl : '0;
                        n_rsp.armed = n_found;
                        n_rsp.last = (r_req.operation != mtds_pkg::OP_TICK);
                        n_rsp_valid = 1'b1;
                        n_state = mtds_pkg::S_WAIT;
                    end else if (n_fires != 6'(MAX_FIRES) && n_found
                            && n_best_dl < r_req.now_ms) begin
                        n_state = mtds_pkg::S_FIRE_RD;
                    end else begin
                        n_rsp.kind = mtds_pkg::KIND_TICK_DONE;
                        n_rsp.timer_slot = '0; n_rsp.status = mtds_pkg::ST_OK;
                        n_rsp.next_deadline_ms = n_found ? n_best_dl : '0;
                        n_rsp.armed = n_found; n_rsp.last = 1'b1;
                        n_rsp_valid = 1'b1;
                        n_state = mtds_pkg::S_WAIT;
                    end
                end
            end
            mtds_pkg::S_FIRE_RD: begin
                w_raddr = r_best;
                n_state = mtds_pkg::S_FIRE_WR;
            end
            mtds_pkg::S_FIRE_WR: begin
                // re-arm periodic timer or free one-shot
                w_sum = {1'b0, r_best_dl} + {17'd0, w_pr_rdata};
                if (w_pr_rdata != '0) begin
                    w_we = 1'b1; w_waddr = r_best;
                    w_dl_wdata = w_sum[48] ? mtds_pkg::MAX48 : w_sum[47:0];
                end else begin
                    n_valid[r_best] = 1'b0;
                end
                n_fires = r_fires + 6'd1;
                n_rsp.kind = mtds_pkg::KIND_FIRED;
                n_rsp.timer_slot = 4'(r_best);
                n_rsp.status = mtds_pkg::ST_OK;
                n_post = 1'b1;
                n_cnt = '0; n_found = 1'b0;
                n_state = mtds_pkg::S_SCAN;
            end
            mtds_pkg::S_WAIT: begin
                if (!i_rsp_stall) begin
                    n_rsp_valid = 1'b0;
                    if (r_rsp.last) begin
                        n_state = mtds_pkg::S_IDLE;
                    end else if (r_fires != 6'(MAX_FIRES) && r_found
                            && r_best_dl < r_req.now_ms) begin
                        // next firing was found by the scan
                        n_post = 1'b0;
                        n_state = mtds_pkg::S_FIRE_RD;
                    end else begin
                        // close the tick; the table is unchanged since the scan
                        n_rsp.kind = mtds_pkg::KIND_TICK_DONE;
                        n_rsp.timer_slot = '0; n_rsp.status = mtds_pkg::ST_OK;
                        n_rsp.last = 1'b1;
                        n_rsp_valid = 1'b1;
                    end
                end
            end
            default: n_state = mtds_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtds_pkg::S_IDLE;
            r_valid <= '0;
            r_rsp_valid <= 1'b0;
            r_cnt <= '0;
            r_fires <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_rsp_valid <= n_rsp_valid;
            r_cnt <= n_cnt;
            r_fires <= n_fires;
        end
        r_req <= n_req; r_best <= n_best; r_best_dl <= n_best_dl; r_found <= n_found;
        r_acc <= n_acc; r_mhalf <= n_mhalf; r_rsp <= n_rsp;
        r_free_ok <= n_free_ok; r_free <= n_free; r_post <= n_post;
    end

    assign o_req_stall = (r_state != mtds_pkg::S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    `include "multi_timer_deadline_scheduler_assert.svh"
    `MTDS_ASSERT_IMP(a_rsp_only_wait, i_clk, i_rst_n, r_rsp_valid, r_state == mtds_pkg::S_WAIT)
    `MTDS_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_rsp_valid, o_req_stall)
    `MTDS_ASSERT_NXT(a_hold_stalled, i_clk, i_rst_n, r_rsp_valid && i_rsp_stall,
        r_rsp_valid && $stable(r_rsp))
    `MTDS_ASSERT_IMP(a_fire_limit, i_clk, i_rst_n, 1'b1, r_fires <= 6'(MAX_FIRES))
endmodule

>>> hw/rtl/mtds_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read
module mtds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/mtds_div.sv
// Restoring serial divider, one quotient bit per cycle
module mtds_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtds_pkg::t_div_ctl i_ctl,
    output mtds_pkg::t_div_sts o_sts
);
    logic [47:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_dsr, n_dsr;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_shift;

    // step one bit of the division
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_shift = {r_rem[31:0], r_quo[47]};
        if (i_ctl.start) begin
            n_quo  = i_ctl.dividend;
            n_rem  = '0;
            n_dsr  = i_ctl.divisor;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_dsr}) begin
                n_rem = w_shift - {1'b0, r_dsr};
                n_quo = {r_quo[46:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[46:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd47) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_sts.done     = r_done;
    assign o_sts.quotient = r_quo;
endmodule

>>> verif/multi_timer_deadline_scheduler_tb.sv
// Testbench of the timer scheduler: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module multi_timer_deadline_scheduler_tb;

    localparam int          SLOTS     = 16;
    localparam int          MAX_FIRES = 63;
    localparam int          WD_LIMIT  = 40000;
    localparam logic [47:0] M48       = 48'hFFFF_FFFF_FFFF;

    // Timer table predictor and queue of expected results
    class timer_scoreboard;
        logic [47:0]    due_at [SLOTS];
        logic [31:0]    interval [SLOTS];
        bit             busy [SLOTS];
        mtds_pkg::t_rsp pending_rsp [$];
        int             mismatches;

        function new();
            mismatches = 0;
            for (int i = 0; i < SLOTS; i++) begin
                busy[i] = 0;
                due_at[i] = '0;
                interval[i] = '0;
            end
        endfunction

        function int earliest();
            int b;
            b = -1;
            for (int i = 0; i < SLOTS; i++)
                if (busy[i] && (b < 0 || due_at[i] < due_at[b])) b = i;
            return b;
        endfunction

        function void push(mtds_pkg::t_kind k, int slot, mtds_pkg::t_status st, bit lst);
            mtds_pkg::t_rsp r;
            int             e;
            e = earliest();
            r.kind = k;
            r.timer_slot = slot[3:0];
            r.status = st;
            r.next_deadline_ms = (e >= 0) ? due_at[e] : '0;
            r.armed = (e >= 0);
            r.last = lst;
            pending_rsp.push_back(r);
        endfunction

        function logic [47:0] sat(logic [63:0] v);
            return (v > {16'd0, M48}) ? M48 : v[47:0];
        endfunction

        // Note an accepted request and predict its results
        function void note_request(mtds_pkg::t_req q);
            int          e, n, fs;
            logic [63:0] delta, steps, w;
            case (mtds_pkg::t_op'(q.operation))
                mtds_pkg::OP_TICK: begin
                    n = 0;
                    while (n < MAX_FIRES) begin
                        e = earliest();
                        if (e < 0 || !(due_at[e] < q.now_ms)) break;
                        if (interval[e] != 0)
                            due_at[e] = sat({16'd0, due_at[e]} + interval[e]);
                        else
                            busy[e] = 0;
                        push(mtds_pkg::KIND_FIRED, e, mtds_pkg::ST_OK, 0);
                        n++;
                    end
                    push(mtds_pkg::KIND_TICK_DONE, 0, mtds_pkg::ST_OK, 1);
                end
                mtds_pkg::OP_STOP: begin
                    if (busy[q.slot_id]) begin
                        busy[q.slot_id] = 0;
                        push(mtds_pkg::KIND_STOP, q.slot_id, mtds_pkg::ST_OK, 1);
                    end else begin
                        push(mtds_pkg::KIND_STOP, q.slot_id, mtds_pkg::ST_NOT_FOUND, 1);
                    end
                end
                default: begin
                    fs = -1;
                    for (int i = SLOTS - 1; i >= 0; i--) if (!busy[i]) fs = i;
                    if (fs < 0) begin
                        push(mtds_pkg::KIND_START, 0, mtds_pkg::ST_FULL, 1);
                    end else begin
                        if (mtds_pkg::t_op'(q.operation) == mtds_pkg::OP_START_AT) begin
                            w = {16'd0, q.start_ms};
                            if (q.period_ms != 0 && q.now_ms > q.start_ms) begin
                                delta = {16'd0, q.now_ms - q.start_ms};
                                steps = delta / q.period_ms + 1;
                                w = {16'd0, sat({16'd0, q.start_ms} + steps * q.period_ms)};
                            end
                        end else begin
                            w = {16'd0, sat({16'd0, q.now_ms} + q.start_ms)};
                        end
                        due_at[fs] = w[47:0];
                        interval[fs] = q.period_ms;
                        busy[fs] = 1;
                        push(mtds_pkg::KIND_START, fs, mtds_pkg::ST_OK, 1);
                    end
                end
            endcase
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(mtds_pkg::t_rsp got);
            mtds_pkg::t_rsp want;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending_rsp.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_req_valid, o_req_stall, o_rsp_valid, i_rsp_stall;
    mtds_pkg::t_req i_req;
    mtds_pkg::t_rsp o_rsp;

    timer_scoreboard sb;
    int  send_idle_pct, recv_idle_pct, idle_cycles;
    longint sim_now;

    multi_timer_deadline_scheduler DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_stall(o_req_stall), .i_req(i_req),
        .o_rsp_valid(o_rsp_valid), .i_rsp_stall(i_rsp_stall), .o_rsp(o_rsp)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req = '0;
        i_rsp_stall = 1'b0;
        send_idle_pct = 6;
        recv_idle_pct = 78;
        sb = new();
    end

    // Randomly stall the result side
    always @(posedge i_clk)
        i_rsp_stall <= ($urandom_range(99) < recv_idle_pct);

    // Check results and watch for a hang
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_rsp_valid && !i_rsp_stall) sb.check_result(o_rsp);
            if ((o_rsp_valid && !i_rsp_stall) || (i_req_valid && !o_req_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Present one request and hold it until accepted; valid stays up for the next one
    task automatic send_request(mtds_pkg::t_req q);
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= q;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        sb.note_request(q);
    endtask

    task automatic send_op(mtds_pkg::t_op op, logic [47:0] now, logic [47:0] st,
                           logic [31:0] per, logic [3:0] sid);
        mtds_pkg::t_req q;
        q.operation = op;
        q.now_ms = now;
        q.start_ms = st;
        q.period_ms = per;
        q.slot_id = sid;
        send_request(q);
    endtask

    // Drop valid and wait for every expected result
    task automatic drain();
        i_req_valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Random request weighted toward realistic timer use, some noise
    task automatic random_request();
        int          sel;
        logic [31:0] per;
        logic [47:0] st;
        sel = $urandom_range(99);
        if ($urandom_range(9) == 0) sim_now = longint'(rand48());
        else sim_now += $urandom_range(200);
        sim_now &= M48;
        per = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 120);
        if ($urandom_range(19) == 0) per = $urandom();
        if (sel < 35) begin
            send_op(mtds_pkg::OP_TICK, sim_now[47:0], rand48(), $urandom(), 4'($urandom()));
        end else if (sel < 55) begin
            st = (sim_now > 500) ? 48'(sim_now - $urandom_range(500))
                                 : 48'($urandom_range(500));
            if ($urandom_range(9) == 0) st = rand48();
            send_op(mtds_pkg::OP_START_AT, sim_now[47:0], st, per, 4'($urandom()));
        end else if (sel < 80) begin
            st = 48'($urandom_range(300));
            if ($urandom_range(14) == 0) st = rand48();
            send_op(mtds_pkg::OP_START_AFTER, sim_now[47:0], st, per, 4'($urandom()));
        end else begin
            send_op(mtds_pkg::OP_STOP, sim_now[47:0], rand48(), $urandom(), 4'($urandom()));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, table full, stop of free slot, past starts
        send_op(mtds_pkg::OP_TICK, '0, '0, '0, 4'd0);
        send_op(mtds_pkg::OP_STOP, 48'd5, M48, 32'hFFFF_FFFF, 4'd15);
        send_op(mtds_pkg::OP_START_AT, 48'd1000, 48'd10, 32'd7, 4'd0);
        send_op(mtds_pkg::OP_START_AT, 48'd1000, 48'd10, 32'd0, 4'd0);
        send_op(mtds_pkg::OP_START_AT, M48, 48'd0, 32'hFFFF_FFFF, 4'd0);
        send_op(mtds_pkg::OP_START_AFTER, M48, M48, 32'd3, 4'd0);
        send_op(mtds_pkg::OP_START_AFTER, 48'd100, 48'd5, 32'd1, 4'd0);
        send_op(mtds_pkg::OP_START_AFTER, 48'd100, 48'd5, 32'd0, 4'd0);
        for (int i = 0; i < 9; i++)
            send_op(mtds_pkg::OP_START_AFTER, 48'd100, 48'd50, 32'd0, 4'd0);
        send_op(mtds_pkg::OP_START_AFTER, 48'd0, 48'd1, 32'd0, 4'd0);
        send_op(mtds_pkg::OP_STOP, 48'd0, '0, '0, 4'd4);
        send_op(mtds_pkg::OP_STOP, 48'd0, '0, '0, 4'd4);
        send_op(mtds_pkg::OP_TICK, 48'd1200, '0, '0, 4'd0);
        send_op(mtds_pkg::OP_TICK, 48'd1300, '0, '0, 4'd0);
        send_op(mtds_pkg::OP_TICK, M48, M48, 32'hFFFF_FFFF, 4'hF);
        drain();

        // Random phases with heavy idling on one side or the other, then none
        sim_now = 1000;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 78 : 0;
            recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 6 : 0;
            for (int k = 0; k < 119; k++) begin
                random_request();
                if (k == 60) drain();
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
